@@ src/bfit_pkg.sv @@
// Shared constants, operation codes and controller/datapath interface types.
package bfit_pkg;

  localparam int MaxFilterBytes = 4096;
  localparam int MaxElemBytes   = 64;
  localparam int MaxHashCount   = 50;
  localparam int FaddrW         = $clog2(MaxFilterBytes);
  localparam int BaddrW         = $clog2(MaxElemBytes);
  localparam int LenW           = BaddrW + 1;

  localparam logic [31:0] SeedStep = 32'hFBA4C795;
  localparam logic [31:0] MurC1    = 32'hcc9e2d51;
  localparam logic [31:0] MurC2    = 32'h1b873593;
  localparam logic [31:0] MurC3    = 32'h85ebca6b;
  localparam logic [31:0] MurC4    = 32'hc2b2ae35;
  localparam logic [31:0] MixAdd   = 32'he6546b64;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_TEST = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  localparam logic [1:0] CFG_TWEAK  = 2'd0;
  localparam logic [1:0] CFG_HASHES = 2'd1;
  localparam logic [1:0] CFG_FBYTES = 2'd2;

  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_TAKE   = 5'd1;
  localparam logic [4:0] OP_CLR    = 5'd2;
  localparam logic [4:0] OP_SEED0  = 5'd3;
  localparam logic [4:0] OP_HINIT  = 5'd4;
  localparam logic [4:0] OP_KCLR   = 5'd5;
  localparam logic [4:0] OP_MUL_C1 = 5'd6;
  localparam logic [4:0] OP_ROT15  = 5'd7;
  localparam logic [4:0] OP_MUL_C2 = 5'd8;
  localparam logic [4:0] OP_MIXH   = 5'd9;
  localparam logic [4:0] OP_TAILH  = 5'd10;
  localparam logic [4:0] OP_FIN1   = 5'd11;
  localparam logic [4:0] OP_MUL_C3 = 5'd12;
  localparam logic [4:0] OP_FIN2   = 5'd13;
  localparam logic [4:0] OP_MUL_C4 = 5'd14;
  localparam logic [4:0] OP_FIN3   = 5'd15;
  localparam logic [4:0] OP_DIV    = 5'd16;
  localparam logic [4:0] OP_FWR    = 5'd17;
  localparam logic [4:0] OP_MISS   = 5'd18;
  localparam logic [4:0] OP_NEXT   = 5'd19;
  localparam logic [4:0] OP_END    = 5'd20;

  typedef struct packed {
    logic [4:0] op;
    logic       rd;
    logic       cap;
    logic [1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic [LenW-1:0] rem;
    logic            k_zero;
    logic [5:0]      k_num;
    logic            clr_last;
    logic            bit_set;
    logic            was_test;
  } dp_stat_t;

endpackage

@@ src/bfit_dp.sv @@
// Datapath: config registers, element buffer, hash unit, modulo unit, filter store.
module bfit_dp (
  input  logic               clk,
  input  logic               rst,
  input  bfit_pkg::dp_cmd_t  cmd,
  input  logic [1:0]         req_type,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic [11:0]        filter_byte_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output bfit_pkg::dp_stat_t stat,
  output logic               was_test,
  output logic               matched,
  output logic               too_long
);
  import bfit_pkg::*;

  logic [31:0]       tweak;
  logic [5:0]        hashes;
  logic [12:0]       fbytes;
  logic [7:0]        ebuf [MaxElemBytes];
  logic [7:0]        buf_q;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   pos;
  logic              ovf;
  logic              wtest;
  logic              match_ok;
  logic [31:0]       seed;
  logic [31:0]       h;
  logic [31:0]       kw;
  logic [31:0]       prod;
  logic [31:0]       q;
  logic [15:0]       r;
  logic [FaddrW-1:0] caddr;
  logic [7:0]        fmem [MaxFilterBytes];
  logic [7:0]        fq;

  logic [12:0]       nbytes;
  logic [15:0]       nbits;
  logic [5:0]        kclamp;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       mix_t;
  logic [31:0]       mix_r;
  logic [31:0]       fin_t;
  logic [16:0]       div_t;
  logic              elem_take;
  logic              fwe;
  logic [FaddrW-1:0] fwa;
  logic [7:0]        fwd;

  always_comb begin
    if (fbytes == 13'd0) begin
      nbytes = 13'd1;
    end else if (fbytes > 13'(MaxFilterBytes)) begin
      nbytes = 13'(MaxFilterBytes);
    end else begin
      nbytes = fbytes;
    end
    nbits  = {nbytes, 3'b000};
    kclamp = (hashes > 6'(MaxHashCount)) ? 6'(MaxHashCount) : hashes;
  end

  always_comb begin
    case (cmd.op)
      OP_MUL_C1: begin mul_a = kw; mul_b = MurC1; end
      OP_MUL_C2: begin mul_a = kw; mul_b = MurC2; end
      OP_MUL_C3: begin mul_a = h;  mul_b = MurC3; end
      default:   begin mul_a = h;  mul_b = MurC4; end
    endcase
    mix_t = h ^ prod;
    mix_r = {mix_t[18:0], mix_t[31:19]};
    fin_t = h ^ {{(32-LenW){1'b0}}, len};
    div_t = {r, q[31]};
  end

  assign elem_take = (cmd.op == OP_TAKE) &&
                     ((req_type == REQ_ADD) || (req_type == REQ_TEST));

  always_comb begin
    fwe = 1'b0;
    fwa = r[FaddrW+2:3];
    fwd = fq | (8'b1 << r[2:0]);
    case (cmd.op)
      OP_CLR: begin
        fwe = 1'b1;
        fwa = caddr;
        fwd = 8'd0;
      end
      OP_TAKE: begin
        fwe = (req_type == REQ_LOAD);
        fwa = filter_byte_index;
        fwd = data_byte;
      end
      OP_FWR: begin
        fwe = 1'b1;
      end
      default: begin
        fwe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      fmem[fwa] <= fwd;
    end
    fq <= fmem[r[FaddrW+2:3]];
  end

  always_ff @(posedge clk) begin
    if (elem_take && (len < LenW'(MaxElemBytes))) begin
      ebuf[len[BaddrW-1:0]] <= data_byte;
    end
    buf_q <= ebuf[pos[BaddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tweak  <= 32'd0;
      hashes <= 6'd1;
      fbytes <= 13'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TWEAK:  tweak  <= cfg_data;
        CFG_HASHES: hashes <= cfg_data[5:0];
        CFG_FBYTES: fbytes <= cfg_data[12:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      ovf      <= 1'b0;
      caddr    <= '0;
      wtest    <= 1'b0;
      match_ok <= 1'b0;
    end else begin
      if (elem_take) begin
        if (len < LenW'(MaxElemBytes)) begin
          len <= len + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
        if (last_byte) begin
          wtest    <= (req_type == REQ_TEST);
          match_ok <= 1'b1;
        end
      end
      if (cmd.op == OP_CLR) begin
        caddr <= caddr + 1'b1;
      end
      if (cmd.op == OP_MISS) begin
        match_ok <= 1'b0;
      end
      if (cmd.op == OP_END) begin
        len <= '0;
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      pos <= pos + 1'b1;
    end
    if (cmd.cap) begin
      kw <= kw | ({24'd0, buf_q} << {cmd.lane, 3'b000});
    end
    case (cmd.op)
      OP_SEED0:  seed <= tweak;
      OP_NEXT:   seed <= seed + SeedStep;
      OP_HINIT: begin
        h   <= seed;
        pos <= '0;
      end
      OP_KCLR:   kw   <= 32'd0;
      OP_MUL_C1, OP_MUL_C2, OP_MUL_C3, OP_MUL_C4: prod <= mul_a * mul_b;
      OP_ROT15:  kw   <= {prod[16:0], prod[31:17]};
      OP_MIXH:   h    <= mix_r + {mix_r[29:0], 2'b00} + MixAdd;
      OP_TAILH:  h    <= h ^ prod;
      OP_FIN1:   h    <= fin_t ^ (fin_t >> 16);
      OP_FIN2:   h    <= prod ^ (prod >> 13);
      OP_FIN3: begin
        q <= prod ^ (prod >> 16);
        r <= 16'd0;
      end
      OP_DIV: begin
        q <= {q[30:0], 1'b0};
        if (div_t >= {1'b0, nbits}) begin
          r <= 16'(div_t - {1'b0, nbits});
        end else begin
          r <= div_t[15:0];
        end
      end
      default: ;
    endcase
  end

  assign stat.rem      = len - pos;
  assign stat.k_zero   = (kclamp == 6'd0);
  assign stat.k_num    = kclamp;
  assign stat.clr_last = (caddr == FaddrW'(MaxFilterBytes - 1));
  assign stat.bit_set  = fq[r[2:0]];
  assign stat.was_test = wtest;

  assign was_test = wtest;
  assign matched  = wtest & match_ok;
  assign too_long = ovf;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LenW'(MaxElemBytes))
    else $error("element length beyond buffer");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (len == LenW'(MaxElemBytes)))
    else $error("overflow flagged with buffer not full");

endmodule

@@ src/bfit_ctrl.sv @@
// Controller: sequences clearing, byte intake, per-hash murmur rounds, modulo and filter access.
module bfit_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  logic               last_byte,
  input  bfit_pkg::dp_stat_t stat,
  output bfit_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import bfit_pkg::*;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_START = 5'd2;
  localparam logic [4:0] S_HINIT = 5'd3;
  localparam logic [4:0] S_BLK   = 5'd4;
  localparam logic [4:0] S_FETCH = 5'd5;
  localparam logic [4:0] S_M1    = 5'd6;
  localparam logic [4:0] S_ROT   = 5'd7;
  localparam logic [4:0] S_M2    = 5'd8;
  localparam logic [4:0] S_MIX   = 5'd9;
  localparam logic [4:0] S_FIN1  = 5'd10;
  localparam logic [4:0] S_M3    = 5'd11;
  localparam logic [4:0] S_FIN2  = 5'd12;
  localparam logic [4:0] S_M4    = 5'd13;
  localparam logic [4:0] S_FIN3  = 5'd14;
  localparam logic [4:0] S_DIV   = 5'd15;
  localparam logic [4:0] S_FRD   = 5'd16;
  localparam logic [4:0] S_FCHK  = 5'd17;
  localparam logic [4:0] S_NEXT  = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [2:0] fc;
  logic [2:0] fc_next;
  logic [2:0] nf;
  logic [2:0] nf_next;
  logic       full;
  logic       full_next;
  logic [4:0] dcnt;
  logic [4:0] dcnt_next;
  logic [5:0] hidx;
  logic [5:0] hidx_next;
  logic [1:0] lane_m1;

  assign lane_m1 = 2'(fc - 3'd1);

  always_comb begin
    state_next = state;
    fc_next    = fc;
    nf_next    = nf;
    full_next  = full;
    dcnt_next  = dcnt;
    hidx_next  = hidx;
    cmd        = '0;
    cmd.op     = OP_NONE;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_TAKE;
          if (last_byte && ((req_type == REQ_ADD) || (req_type == REQ_TEST))) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.op    = OP_SEED0;
        hidx_next = 6'd0;
        state_next = stat.k_zero ? S_DONE : S_HINIT;
      end
      S_HINIT: begin
        cmd.op     = OP_HINIT;
        state_next = S_BLK;
      end
      S_BLK: begin
        if (stat.rem == '0) begin
          state_next = S_FIN1;
        end else begin
          cmd.op     = OP_KCLR;
          full_next  = (stat.rem >= LenW'(4));
          nf_next    = (stat.rem >= LenW'(4)) ? 3'd4 : {1'b0, stat.rem[1:0]};
          fc_next    = 3'd0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd   = (fc < nf);
        cmd.cap  = (fc != 3'd0);
        cmd.lane = lane_m1;
        fc_next  = fc + 3'd1;
        if (fc == nf) begin
          state_next = S_M1;
        end
      end
      S_M1: begin
        cmd.op     = OP_MUL_C1;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op     = OP_ROT15;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.op     = OP_MUL_C2;
        state_next = S_MIX;
      end
      S_MIX: begin
        if (full) begin
          cmd.op     = OP_MIXH;
          state_next = S_BLK;
        end else begin
          cmd.op     = OP_TAILH;
          state_next = S_FIN1;
        end
      end
      S_FIN1: begin
        cmd.op     = OP_FIN1;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.op     = OP_MUL_C3;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        cmd.op     = OP_FIN2;
        state_next = S_M4;
      end
      S_M4: begin
        cmd.op     = OP_MUL_C4;
        state_next = S_FIN3;
      end
      S_FIN3: begin
        cmd.op     = OP_FIN3;
        dcnt_next  = 5'd0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        dcnt_next = dcnt + 5'd1;
        if (dcnt == 5'd31) begin
          state_next = S_FRD;
        end
      end
      S_FRD: begin
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (stat.was_test) begin
          if (!stat.bit_set) begin
            cmd.op     = OP_MISS;
            state_next = S_DONE;
          end else begin
            state_next = S_NEXT;
          end
        end else begin
          cmd.op     = OP_FWR;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.op    = OP_NEXT;
        hidx_next = hidx + 6'd1;
        state_next = (hidx + 6'd1 == stat.k_num) ? S_DONE : S_HINIT;
      end
      S_DONE: begin
        cmd.op     = OP_END;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      fc    <= 3'd0;
      nf    <= 3'd0;
      full  <= 1'b0;
      dcnt  <= 5'd0;
      hidx  <= 6'd0;
    end else begin
      state <= state_next;
      fc    <= fc_next;
      nf    <= nf_next;
      full  <= full_next;
      dcnt  <= dcnt_next;
      hidx  <= hidx_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("not ready after result");

  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> ((fc <= nf) && (nf != 3'd0) && (nf <= 3'd4)))
    else $error("fetch counter out of range");

endmodule

@@ src/bloom_filter_insert_and_test_top.sv @@
// Top level: bloom filter insert and test with murmur3 hashing over a 32768-bit store.
// Reset starts a clearing pass over the 4096-byte store, one byte a cycle; busy is high throughout.
// A load or a non-final element byte is taken in the idle state. A final byte then runs, per hash,
// murmur rounds over each four-byte block and any tail, a modulo and a filter access; a test miss skips the rest.
// One transaction at a time; a shared 32x32 multiplier and a 32-step restoring divider set the cost.
// done pulses one cycle with the result; the receiver cannot stall it.
module bloom_filter_insert_and_test_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [11:0] filter_byte_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        was_test,
  output logic        matched,
  output logic        too_long
);
  import bfit_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .last_byte (last_byte),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  bfit_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .req_type          (req_type),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .filter_byte_index (filter_byte_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .stat              (stat),
    .was_test          (was_test),
    .matched           (matched),
    .too_long          (too_long)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the bloom filter insert and test block.
module testbench;
  import bfit_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic was_test;
    logic matched;
    logic too_long;
  } verdict_t;

  class bloom_ledger;
    logic [7:0]  fbits[MaxFilterBytes];
    logic [7:0]  ebuf[MaxElemBytes];
    int unsigned elen;
    logic        ovf;
    logic [31:0] tweak;
    logic [5:0]  hcount;
    logic [12:0] fbytes;
    verdict_t    verdicts[$];
    int          errors;
    int          results;
    int          hits;
    int          overlong;

    function new();
      foreach (fbits[i]) fbits[i] = 8'h00;
      foreach (ebuf[i]) ebuf[i] = 8'h00;
      elen = 0;
      ovf = 1'b0;
      tweak = 32'd0;
      hcount = 6'd1;
      fbytes = 13'd64;
      errors = 0;
      results = 0;
      hits = 0;
      overlong = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_TWEAK: tweak = val;
        CFG_HASHES: hcount = val[5:0];
        CFG_FBYTES: fbytes = val[12:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] murmur(logic [31:0] seed);
      logic [31:0] h;
      logic [31:0] k;
      int unsigned nblk;
      int unsigned tail;
      h = seed;
      nblk = elen / 4;
      for (int unsigned i = 0; i < nblk; i++) begin
        k = {ebuf[4*i+3], ebuf[4*i+2], ebuf[4*i+1], ebuf[4*i]};
        k = k * MurC1;
        k = rotl(k, 15);
        k = k * MurC2;
        h = h ^ k;
        h = rotl(h, 13);
        h = h * 32'd5 + MixAdd;
      end
      k = 32'd0;
      tail = elen & 3;
      if (tail >= 3) k = k ^ {8'h00, ebuf[4*nblk+2], 16'h0000};
      if (tail >= 2) k = k ^ {16'h0000, ebuf[4*nblk+1], 8'h00};
      if (tail >= 1) begin
        k = k ^ {24'h000000, ebuf[4*nblk]};
        k = k * MurC1;
        k = rotl(k, 15);
        k = k * MurC2;
        h = h ^ k;
      end
      h = h ^ elen;
      h = h ^ (h >> 16);
      h = h * MurC3;
      h = h ^ (h >> 13);
      h = h * MurC4;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function void note_request(logic [1:0] rt, logic [7:0] d, logic lb, logic [11:0] fi);
      logic [31:0] nbits;
      logic [31:0] bsel;
      int unsigned nb;
      int unsigned kk;
      logic        all_set;
      verdict_t    v;
      if (rt == REQ_LOAD) begin
        fbits[fi] = d;
        return;
      end
      if (rt == REQ_NONE) return;
      if (elen < MaxElemBytes) begin
        ebuf[elen] = d;
        elen++;
      end else begin
        ovf = 1'b1;
      end
      if (!lb) return;
      nb = fbytes;
      if (nb < 1) nb = 1;
      if (nb > MaxFilterBytes) nb = MaxFilterBytes;
      nbits = nb * 8;
      kk = hcount;
      if (kk > MaxHashCount) kk = MaxHashCount;
      all_set = 1'b1;
      for (int unsigned i = 0; i < kk; i++) begin
        bsel = murmur(SeedStep * i + tweak) % nbits;
        if (rt == REQ_TEST) begin
          if (!fbits[bsel >> 3][bsel[2:0]]) begin
            all_set = 1'b0;
            break;
          end
        end else begin
          fbits[bsel >> 3][bsel[2:0]] = 1'b1;
        end
      end
      v.was_test = (rt == REQ_TEST);
      v.matched = (rt == REQ_TEST) && all_set;
      v.too_long = ovf;
      verdicts.push_back(v);
      elen = 0;
      ovf = 1'b0;
    endfunction

    function void check_result(logic wt, logic m, logic tl);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result with no transaction pending: was_test %0d matched %0d too_long %0d",
               wt, m, tl);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      results++;
      if (m) hits++;
      if (tl) overlong++;
      if (wt !== v.was_test) begin
        $error("was_test expected %0d actual %0d", v.was_test, wt);
        errors++;
      end
      if (m !== v.matched) begin
        $error("matched expected %0d actual %0d", v.matched, m);
        errors++;
      end
      if (tl !== v.too_long) begin
        $error("too_long expected %0d actual %0d", v.too_long, tl);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [11:0] filter_byte_index;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  logic        was_test;
  logic        matched;
  logic        too_long;

  bloom_ledger ledger;
  int          sent;
  bit          calm;
  logic [7:0]  pool_data[16][72];
  int          pool_len[16];
  int          pool_fill;

  bloom_filter_insert_and_test_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .filter_byte_index(filter_byte_index),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .was_test(was_test),
    .matched(matched),
    .too_long(too_long)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) ledger.check_result(was_test, matched, too_long);
  end

  task automatic send(logic [1:0] rt, logic [7:0] d, logic lb, logic [11:0] fi);
    start <= 1'b1;
    req_type <= rt;
    data_byte <= d;
    last_byte <= lb;
    filter_byte_index <= fi;
    do @(posedge clk); while (busy);
    ledger.note_request(rt, d, lb, fi);
    sent++;
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.verdicts.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    ledger.set_reg(idx, val);
  endtask

  task automatic send_element(logic [1:0] fin, int len, int slot, bit mixed);
    logic [1:0] rt;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1)) send(REQ_LOAD, 8'($urandom), 1'($urandom), 12'($urandom));
        else send(REQ_NONE, 8'($urandom), 1'($urandom), 12'($urandom));
        maybe_idle();
      end
      rt = (i == len - 1 || !mixed) ? fin : 2'($urandom_range(0, 1));
      send(rt, pool_data[slot][i], i == len - 1, 12'($urandom));
      maybe_idle();
    end
  endtask

  task automatic random_element();
    int  slot;
    int  len;
    bit  reuse;
    reuse = pool_fill > 0 && $urandom_range(0, 1);
    if (reuse) begin
      slot = $urandom_range(0, pool_fill - 1);
      len = pool_len[slot];
      send_element($urandom_range(0, 3) == 0 ? REQ_ADD : REQ_TEST, len, slot,
                   $urandom_range(0, 3) == 0);
    end else begin
      slot = (pool_fill < 16) ? pool_fill : $urandom_range(0, 15);
      if (pool_fill < 16) pool_fill++;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) pool_data[slot][i] = 8'($urandom);
      pool_len[slot] = len;
      send_element($urandom_range(0, 2) == 0 ? REQ_TEST : REQ_ADD, len, slot,
                   $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    logic [5:0]  hc_list[10];
    logic [12:0] fb_list[10];
    int          target;
    hc_list = '{6'd1, 6'd3, 6'd0, 6'd50, 6'd63, 6'd2, 6'd8, 6'd1, 6'd5, 6'd4};
    fb_list = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd64, 13'd2, 13'd300, 13'd16,
                13'd4097, 13'd40};
    ledger = new();
    sent = 0;
    calm = 1'b0;
    pool_fill = 0;
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= REQ_ADD;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    filter_byte_index <= 12'd0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TWEAK;
    cfg_data <= 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    send(REQ_ADD, 8'h00, 1'b1, 12'd0);
    send(REQ_TEST, 8'h00, 1'b1, 12'd0);
    send(REQ_TEST, 8'hFF, 1'b1, 12'hFFF);
    send(REQ_ADD, 8'hFF, 1'b0, 12'd0);
    send(REQ_TEST, 8'h01, 1'b0, 12'd0);
    send(REQ_ADD, 8'h80, 1'b1, 12'd0);
    send(REQ_TEST, 8'hFF, 1'b0, 12'd0);
    send(REQ_ADD, 8'h01, 1'b0, 12'd0);
    send(REQ_TEST, 8'h80, 1'b1, 12'd0);
    send(REQ_NONE, 8'hFF, 1'b1, 12'hFFF);
    send(REQ_LOAD, 8'hFF, 1'b0, 12'd0);
    send(REQ_LOAD, 8'hAA, 1'b1, 12'hFFF);
    send(REQ_LOAD, 8'hFF, 1'b0, 12'd63);
    send(REQ_TEST, 8'h5A, 1'b1, 12'd0);
    send(REQ_ADD, 8'h12, 1'b0, 12'd0);
    send(REQ_LOAD, 8'h00, 1'b0, 12'd63);
    send(REQ_ADD, 8'h34, 1'b0, 12'd0);
    send(REQ_ADD, 8'h56, 1'b1, 12'd0);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_reg(CFG_TWEAK, ph == 0 ? 32'd0 : (ph == 1 ? 32'hFFFF_FFFF : $urandom));
      write_reg(CFG_HASHES, {26'd0, hc_list[ph]});
      write_reg(CFG_FBYTES, {19'd0, fb_list[ph]});
      cfg_we <= 1'b0;
      target = 130 * (ph + 1);
      while (sent < target) begin
        calm = (sent > 1150);
        random_element();
      end
    end
    drain();
    repeat (40) @(posedge clk);
    $display("transactions sent: %0d, results checked: %0d (%0d matched, %0d overlong)",
             sent, ledger.results, ledger.hits, ledger.overlong);
    $display("ten filter settings swept, including zero and saturated hash counts and sizes");
    if (ledger.errors == 0 && ledger.verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      if (ledger.verdicts.size() != 0)
        $error("%0d expected results never arrived", ledger.verdicts.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 100_000_000);
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
